/* rtl/ip_address_text_classifier_core_assert.svh */
// assertion macros for the address classifier
`ifndef IP_ADDRESS_TEXT_CLASSIFIER_CORE_ASSERT_SVH
`define IP_ADDRESS_TEXT_CLASSIFIER_CORE_ASSERT_SVH
// implication checked at every edge outside reset
`define IATC_ASSERT_IMP(lbl, clk, rstn, lhs, rhs) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// next-cycle implication
`define IATC_ASSERT_NXT(lbl, clk, rstn, lhs, rhs) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

/* rtl/iatc_pkg.sv */
`timescale 1ns / 1ps
package iatc_pkg;
  typedef enum logic [1:0] {TrimLead = 2'd0, TrimText = 2'd1, TrimTail = 2'd2} trim_e;
  typedef enum logic [2:0] {
    ClsInvalid = 3'd0, ClsLoopback = 3'd1, ClsPrivate = 3'd2, ClsLinkLocal = 3'd3,
    ClsPublic = 3'd4
  } cls_e;
  localparam int unsigned QDepth = 2;

  // item as accepted
  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       last_char;
  } char_t;

  // finished result
  typedef struct packed {
    logic        parse_ok;
    logic [2:0]  addr_class;
    logic        is_ipv4;
    logic [63:0] addr_upper;
    logic [63:0] addr_lower;
  } res_t;

  // parse summary handed from front to back at end of string
  typedef struct packed {
    logic              ok;
    logic              v4;
    logic [3:0][7:0]   quad;
    logic [7:0][15:0]  grp;
    logic [3:0]        gcnt;
    logic [3:0]        gap_idx;
    logic              gap;
  } summ_t;

  function automatic logic [2:0] v4_class(logic [7:0] a, logic [7:0] b);
    if (a == 8'd0) return ClsInvalid;
    if (a == 8'd127) return ClsLoopback;
    if (a >= 8'd224) return ClsInvalid;
    if (a == 8'd10) return ClsPrivate;
    if (a == 8'd172 && b >= 8'd16 && b <= 8'd31) return ClsPrivate;
    if (a == 8'd192 && b == 8'd168) return ClsPrivate;
    if (a == 8'd100 && b >= 8'd64 && b <= 8'd127) return ClsPrivate;
    if (a == 8'd169 && b == 8'd254) return ClsLinkLocal;
    return ClsPublic;
  endfunction
endpackage

/* rtl/iatc_if.sv */
`timescale 1ns / 1ps
interface iatc_char_if;
  logic                 valid;
  logic                 ready;
  iatc_pkg::char_t      payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface iatc_res_if;
  logic                 valid;
  logic                 ready;
  iatc_pkg::res_t       payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/iatc_front.sv */
`timescale 1ns / 1ps
module iatc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  iatc_pkg::char_t     item_i,
  output logic                push_o,
  output iatc_pkg::summ_t     summ_o
);
  logic [1:0]        trim_q, trim_d;
  logic              fail_q, fail_d, colon_q, colon_d, pcol_q, pcol_d;
  logic [3:0][7:0]   quad_q, quad_d;
  logic [2:0]        qidx_q, qidx_d;
  logic [9:0]        dec_q, dec_d;
  logic [2:0]        dcnt_q, dcnt_d;
  logic              lz_q, lz_d, let_q, let_d, gap_q, gap_d, dot_q, dot_d;
  logic [15:0]       hex_q, hex_d;
  logic [7:0][15:0]  grp_q, grp_d;
  logic [3:0]        gcnt_q, gcnt_d, gidx_q, gidx_d;

  logic [7:0]      c;
  logic            ws, is_hex;
  logic [3:0]      dv;
  logic            oct_ok;
  iatc_pkg::summ_t s;

  assign c = item_i.char_code;
  assign ws = c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d || c == 8'h0c ||
              c == 8'h0b;

  // hex digit decode
  always_comb begin
    is_hex = 1'b1;
    dv = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) dv = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) dv = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) dv = 4'(c - 8'h37);
    else is_hex = 1'b0;
  end

  // character step
  always_comb begin
    trim_d = trim_q; fail_d = fail_q; colon_d = colon_q; pcol_d = pcol_q;
    quad_d = quad_q; qidx_d = qidx_q; dec_d = dec_q; dcnt_d = dcnt_q;
    lz_d = lz_q; let_d = let_q; gap_d = gap_q; dot_d = dot_q; hex_d = hex_q;
    grp_d = grp_q; gcnt_d = gcnt_q; gidx_d = gidx_q;
    oct_ok = dcnt_q != 3'd0 && dcnt_q <= 3'd3 && !let_q && dec_q <= 10'd255 &&
             !(dcnt_q > 3'd1 && lz_q);
    if (item_i.has_char) begin
      if (trim_q == 2'(iatc_pkg::TrimLead) && ws) begin
      end else if (trim_q == 2'(iatc_pkg::TrimTail)) begin
        if (!ws) fail_d = 1'b1;
      end else if (trim_q == 2'(iatc_pkg::TrimText) && ws) begin
        trim_d = 2'(iatc_pkg::TrimTail);
      end else begin
        trim_d = 2'(iatc_pkg::TrimText);
        if (!fail_q) begin
          if (is_hex) begin
            if (pcol_q && !gap_q && gcnt_q == 4'd0) fail_d = 1'b1;
            else if (dot_q ? (dv > 4'd9 || dcnt_q >= 3'd3) : dcnt_q >= 3'd4) begin
              fail_d = 1'b1;
              pcol_d = 1'b0;
            end else begin
              pcol_d = 1'b0;
              if (dcnt_q == 3'd0) lz_d = c == 8'h30;
              if (dv > 4'd9) let_d = 1'b1;
              else dec_d = 10'(dec_q * 10'd10 + 10'(dv));
              hex_d = {hex_q[11:0], dv};
              dcnt_d = dcnt_q + 3'd1;
            end
          end else if (c == 8'h2e) begin
            if (!oct_ok || qidx_q >= 3'd3) fail_d = 1'b1;
            else begin
              quad_d[qidx_q[1:0]] = dec_q[7:0];
              qidx_d = qidx_q + 3'd1;
              dot_d = 1'b1;
              dec_d = '0; dcnt_d = '0; hex_d = '0; lz_d = 1'b0; let_d = 1'b0;
            end
          end else if (c == 8'h3a) begin
            if (dot_q) fail_d = 1'b1;
            else begin
              colon_d = 1'b1;
              if (dcnt_q != 3'd0) begin
                if (gcnt_q >= 4'd8) fail_d = 1'b1;
                else begin
                  grp_d[gcnt_q[2:0]] = hex_q;
                  gcnt_d = gcnt_q + 4'd1;
                end
                dec_d = '0; dcnt_d = '0; hex_d = '0; lz_d = 1'b0; let_d = 1'b0;
                pcol_d = 1'b1;
              end else if (pcol_q) begin
                if (gap_q) fail_d = 1'b1;
                else begin
                  gap_d = 1'b1;
                  gidx_d = gcnt_q;
                end
              end else pcol_d = 1'b1;
            end
          end else fail_d = 1'b1;
        end
      end
    end
  end

  // end-of-string summary from the next-state view
  always_comb begin
    logic ok4;
    ok4 = dcnt_d != 3'd0 && dcnt_d <= 3'd3 && !let_d && dec_d <= 10'd255 &&
          !(dcnt_d > 3'd1 && lz_d);
    s = '0;
    s.quad = quad_d;
    s.quad[3] = dec_d[7:0];
    s.grp = grp_d;
    s.gcnt = gcnt_d;
    s.gap_idx = gidx_d;
    s.gap = gap_d;
    s.ok = !fail_d && trim_d != 2'(iatc_pkg::TrimLead);
    if (dot_d) begin
      if (!ok4 || qidx_d != 3'd3) s.ok = 1'b0;
      else if (!colon_d) s.v4 = 1'b1;
      else if (gcnt_d > 4'd6) s.ok = 1'b0;
      else begin
        s.grp[gcnt_d[2:0]] = {quad_d[0], quad_d[1]};
        s.grp[3'(gcnt_d + 4'd1)] = {quad_d[2], dec_d[7:0]};
        s.gcnt = gcnt_d + 4'd2;
      end
    end else begin
      if (!colon_d) s.ok = 1'b0;
      else if (dcnt_d != 3'd0) begin
        if (gcnt_d >= 4'd8) s.ok = 1'b0;
        else begin
          s.grp[gcnt_d[2:0]] = hex_d;
          s.gcnt = gcnt_d + 4'd1;
        end
      end else if (!(pcol_d && gap_d && gcnt_d == gidx_d)) s.ok = 1'b0;
    end
    if (!s.v4 && (gap_d ? s.gcnt > 4'd7 : s.gcnt != 4'd8)) s.ok = 1'b0;
  end

  assign push_o = acc_i && item_i.last_char;
  assign summ_o = s;

  // state update, cleared after each result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_q <= '0; fail_q <= 1'b0; colon_q <= 1'b0; pcol_q <= 1'b0; qidx_q <= '0;
      dec_q <= '0; dcnt_q <= '0; lz_q <= 1'b0; let_q <= 1'b0; gap_q <= 1'b0;
      dot_q <= 1'b0; hex_q <= '0; gcnt_q <= '0; gidx_q <= '0;
    end else if (acc_i) begin
      if (item_i.last_char) begin
        trim_q <= '0; fail_q <= 1'b0; colon_q <= 1'b0; pcol_q <= 1'b0; qidx_q <= '0;
        dec_q <= '0; dcnt_q <= '0; lz_q <= 1'b0; let_q <= 1'b0; gap_q <= 1'b0;
        dot_q <= 1'b0; hex_q <= '0; gcnt_q <= '0; gidx_q <= '0;
      end else begin
        trim_q <= trim_d; fail_q <= fail_d; colon_q <= colon_d; pcol_q <= pcol_d;
        qidx_q <= qidx_d; dec_q <= dec_d; dcnt_q <= dcnt_d; lz_q <= lz_d; let_q <= let_d;
        gap_q <= gap_d; dot_q <= dot_d; hex_q <= hex_d; gcnt_q <= gcnt_d;
        gidx_q <= gidx_d;
      end
    end
  end

  // store payload
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      quad_q <= quad_d;
      grp_q <= grp_d;
    end
  end
endmodule

/* rtl/iatc_queue.sv */
`timescale 1ns / 1ps
module iatc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  iatc_pkg::summ_t data_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output iatc_pkg::summ_t data_o
);
  localparam int unsigned PtrW = $clog2(iatc_pkg::QDepth);
  iatc_pkg::summ_t mem_q [iatc_pkg::QDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;

  assign full_o = cnt_q == (PtrW+1)'(iatc_pkg::QDepth);
  assign valid_o = cnt_q != '0;
  assign data_o = mem_q[rp_q];

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  // slots
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end
endmodule

/* rtl/iatc_back.sv */
`timescale 1ns / 1ps
`include "ip_address_text_classifier_core_assert.svh"
module iatc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  iatc_pkg::summ_t summ_i,
  output logic            pop_o,
  iatc_res_if.source      res_o
);
  logic [7:0][15:0] g;
  iatc_pkg::res_t   r;
  logic             vld_q;
  iatc_pkg::res_t   res_q;

  // group expansion around the gap
  always_comb begin
    logic [3:0] t;
    t = summ_i.gcnt - summ_i.gap_idx;
    g = '0;
    for (int i = 0; i < 8; i++) begin
      if (!summ_i.gap) g[i] = summ_i.grp[i];
      else if (4'(i) < summ_i.gap_idx) g[i] = summ_i.grp[i];
      else if (4'(i) >= 4'd8 - t) g[i] = summ_i.grp[3'(4'(i) - (4'd8 - t) + summ_i.gap_idx)];
    end
  end

  // classification
  always_comb begin
    r = '0;
    if (summ_i.ok) begin
      r.parse_ok = 1'b1;
      if (summ_i.v4) begin
        r.is_ipv4 = 1'b1;
        r.addr_class = iatc_pkg::v4_class(summ_i.quad[0], summ_i.quad[1]);
        r.addr_lower = {32'd0, summ_i.quad[0], summ_i.quad[1], summ_i.quad[2],
                        summ_i.quad[3]};
      end else if (g[0] == '0 && g[1] == '0 && g[2] == '0 && g[3] == '0 &&
                   g[4] == '0 && g[5] == 16'hffff) begin
        r.is_ipv4 = 1'b1;
        r.addr_class = iatc_pkg::v4_class(g[6][15:8], g[6][7:0]);
        r.addr_lower = {32'd0, g[6], g[7]};
      end else begin
        r.addr_upper = {g[0], g[1], g[2], g[3]};
        r.addr_lower = {g[4], g[5], g[6], g[7]};
        if (r.addr_upper == '0 && r.addr_lower == '0) r.addr_class = iatc_pkg::ClsInvalid;
        else if (r.addr_upper == '0 && r.addr_lower == 64'd1)
          r.addr_class = iatc_pkg::ClsLoopback;
        else if ((g[0] & 16'hfe00) == 16'hfc00) r.addr_class = iatc_pkg::ClsPrivate;
        else if ((g[0] & 16'hffc0) == 16'hfe80) r.addr_class = iatc_pkg::ClsLinkLocal;
        else if ((g[0] & 16'hff00) == 16'hff00) r.addr_class = iatc_pkg::ClsInvalid;
        else r.addr_class = iatc_pkg::ClsPublic;
      end
    end
  end

  assign pop_o = valid_i && (!vld_q || res_o.ready);
  assign res_o.valid = vld_q;
  assign res_o.payload = res_q;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (pop_o) vld_q <= 1'b1;
    else if (res_o.ready) vld_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= r;
  end

  `IATC_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, vld_q && !res_q.parse_ok,
                   res_q.addr_class == iatc_pkg::ClsInvalid && !res_q.is_ipv4)
  `IATC_ASSERT_NXT(a_hold, clk_i, rst_ni, vld_q && !res_o.ready, vld_q && $stable(res_q))
  `IATC_ASSERT_IMP(a_v4_upper, clk_i, rst_ni, vld_q && res_q.is_ipv4,
                   res_q.addr_upper == '0)
endmodule

/* rtl/ip_address_text_classifier_core.sv */
`timescale 1ns / 1ps
// after the last character, its summary is written to the queue and then the result is registered at the output
// throughput: one character per cycle; ready drops only when the two-entry queue is full
// front parser state and the queue reset asynchronously on rst_ni low
// reset leaves the block waiting for leading whitespace of a new string
module ip_address_text_classifier_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  iatc_char_if.sink    in_i,
  iatc_res_if.source   out_o
);
  logic            acc, push, full, qv, pop;
  iatc_pkg::summ_t summ, qd;

  assign in_i.ready = !full;
  assign acc = in_i.valid && in_i.ready;

  iatc_front u_front (
    .clk_i, .rst_ni, .acc_i(acc), .item_i(in_i.payload), .push_o(push), .summ_o(summ)
  );

  iatc_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(summ), .full_o(full), .valid_o(qv),
    .pop_i(pop), .data_o(qd)
  );

  iatc_back u_back (
    .clk_i, .rst_ni, .valid_i(qv), .summ_i(qd), .pop_o(pop), .res_o(out_o)
  );
endmodule
